// ===== rtl/tkr_pkg.sv =====
// ============================================================================
// tkr_pkg - shared types and constants of the top-K rank assigner
// Field widths of the result item and the engine status group.
// ============================================================================
package tkr_pkg;

    localparam int VALUE_W = 32;
    localparam int KCNT_W  = 7;
    localparam int POS_W   = 6;
    localparam int RANK_W  = 6;
    localparam int IN_W    = 40;   // value + rank_count, padded to bytes
    localparam int OUT_W   = 16;   // position + rank, padded to bytes

    // One result item as it waits in the output queue.
    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [RANK_W-1:0] rank;
        logic              ranked;
        logic              last_result;
    } t_result;

    // Ranking engine status toward the loader and the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_status;

endpackage

// ===== rtl/top_k_rank_assigner.sv =====
// ============================================================================
// top_k_rank_assigner - ranks the K largest entries of a loaded list
// Loader, value RAM, job queue, ranking engine and result queue.
// ============================================================================
// Usage:
//   s_axis carries one list element per transfer: tdata holds the signed
//   value and K, tlast marks the final element. K is taken from the final
//   element only and clamped to the list length. Elements beyond
//   MAX_ENTRIES are dropped; tlast still closes the list.
//   m_axis returns one result per stored element, in load order: tdata holds
//   position and rank, tuser the ranked flag, tlast marks the final result.
// Timing:
//   The loader takes one element per cycle while no ranking is pending.
//   After the final element the input stalls while the engine ranks: it
//   compares element i against every element with one comparator, reading
//   one element per scan cycle, then emits the result for element i. The
//   next list is accepted once the last result has been queued.
// Reset and stalls:
//   Reset (synchronous, active low) empties both queues and the element
//   count; RAM content is not cleared. When m_axis stalls, the result queue
//   fills and the engine holds in its emit step until room frees up.
// ============================================================================
module top_k_rank_assigner
    import tkr_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // [31:0] value, [38:32] rank_count, [39] zero
    input  logic             s_axis_tlast,   // is_last
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // [5:0] position, [11:6] rank, [15:12] zero
    output logic [0:0]       m_axis_tuser,   // [0] ranked
    output logic             m_axis_tlast    // last_result
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES+1);
    localparam int JW = 2 * CW;
    localparam int RW = $bits(t_result);

    // RAM write side (loader) and read side (engine)
    logic               w_we;
    logic [AW-1:0]      w_waddr, w_raddr_a, w_raddr_b;
    logic [VALUE_W-1:0] w_wdata, w_rdata_a, w_rdata_b;

    // job queue: {k, n} per finished list
    logic          w_job_push, w_job_full, w_job_pop, w_job_empty;
    logic [JW-1:0] w_job_in, w_job_out;

    // result queue
    logic          w_res_push, w_res_full, w_res_empty;
    t_result       w_res_in, w_res_out;
    logic [RW-1:0] w_res_out_bits;

    t_eng_status   w_status;

    tkr_loader #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_loader (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_value      (s_axis_tdata[VALUE_W-1:0]),
        .i_rank_count (s_axis_tdata[VALUE_W+KCNT_W-1:VALUE_W]),
        .i_last       (s_axis_tlast),
        .o_ready      (s_axis_tready),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata),
        .o_job_push   (w_job_push),
        .o_job        (w_job_in),
        .i_job_full   (w_job_full),
        .i_status     (w_status)
    );

    tkr_ram #(
        .W     (VALUE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    tkr_fifo #(
        .W     (JW),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_empty (w_job_empty)
    );

    tkr_engine #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_job_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .o_raddr_a   (w_raddr_a),
        .i_rdata_a   (w_rdata_a),
        .o_raddr_b   (w_raddr_b),
        .i_rdata_b   (w_rdata_b),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in),
        .i_res_full  (w_res_full),
        .o_status    (w_status)
    );

    tkr_fifo #(
        .W     (RW),
        .DEPTH (4)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (m_axis_tready),
        .o_data  (w_res_out_bits),
        .o_empty (w_res_empty)
    );

    assign w_res_out     = t_result'(w_res_out_bits);
    assign m_axis_tvalid = !w_res_empty;
    assign m_axis_tdata  = OUT_W'({w_res_out.rank, w_res_out.position});
    assign m_axis_tuser  = w_res_out.ranked;
    assign m_axis_tlast  = w_res_out.last_result;

`ifndef NO_ASSERTIONS
    a_no_load_while_ranking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!w_status.busy && w_job_empty))
        else $error("input open while a ranking is pending");
    a_no_ram_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !w_status.busy)
        else $error("value store written during ranking");
    a_done_has_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.done |-> (w_res_push && w_res_in.last_result))
        else $error("ranking ended without final result");
`endif

endmodule

// ===== rtl/tkr_ram.sv =====
// ============================================================================
// tkr_ram - generic RAM
// One write port, two read ports, registered read data.
// ============================================================================
module tkr_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [W-1:0]             o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [W-1:0]             o_rdata_b
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== rtl/tkr_fifo.sv =====
// ============================================================================
// tkr_fifo - small synchronous queue
// Register-based FIFO, power-of-two depth, head visible on o_data.
// ============================================================================
module tkr_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PW = $clog2(DEPTH);

    logic [W-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [PW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) r_wptr <= r_wptr + 1'b1;
            if (w_pop)  r_rptr <= r_rptr + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(DEPTH))
        else $error("fifo count beyond depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && r_cnt != (PW+1)'(DEPTH)) |-> (r_wptr != r_rptr))
        else $error("fifo pointers disagree with count");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wptr == r_rptr))
        else $error("empty fifo with pointer gap");
`endif

endmodule

// ===== rtl/tkr_loader.sv =====
// ============================================================================
// tkr_loader - input front end
// Stores list elements, clamps K on the last one and issues a ranking job.
// ============================================================================
module tkr_loader
    import tkr_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [VALUE_W-1:0]              i_value,
    input  logic [KCNT_W-1:0]               i_rank_count,
    input  logic                            i_last,
    output logic                            o_ready,
    output logic                            o_we,
    output logic [$clog2(MAX_ENTRIES)-1:0]  o_waddr,
    output logic [VALUE_W-1:0]              o_wdata,
    output logic                            o_job_push,
    output logic [2*$clog2(MAX_ENTRIES+1)-1:0] o_job,   // {k, n}
    input  logic                            i_job_full,
    input  t_eng_status                     i_status
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES+1);
    localparam int EW = (CW > KCNT_W) ? CW : KCNT_W;

    logic [CW-1:0] r_count, n_count;
    logic          r_busy, n_busy;
    logic          w_take, w_room;
    logic [CW-1:0] w_n, w_k;
    logic [EW-1:0] w_k_ext, w_n_ext;

    assign o_ready = !r_busy && !i_job_full;
    assign w_take  = i_valid && o_ready;
    assign w_room  = (r_count < CW'(MAX_ENTRIES));

    assign o_we    = w_take && w_room;
    assign o_waddr = r_count[AW-1:0];
    assign o_wdata = i_value;

    // list length including this element when it fits
    assign w_n     = w_room ? (r_count + 1'b1) : r_count;
    assign w_k_ext = EW'(i_rank_count);
    assign w_n_ext = EW'(w_n);
    assign w_k     = (w_k_ext < w_n_ext) ? CW'(i_rank_count) : w_n;

    assign o_job_push = w_take && i_last;
    assign o_job      = {w_k, w_n};

    always_comb begin
        n_count = r_count;
        n_busy  = r_busy;
        if (i_status.done) begin
            n_busy = 1'b0;
        end
        if (w_take) begin
            n_count = w_n;
            if (i_last) begin
                n_count = '0;
                n_busy  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_busy  <= n_busy;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("element count beyond store depth");
    a_busy_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_count == '0))
        else $error("elements stored while a ranking runs");
    a_job_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |-> (w_k <= w_n && w_n != '0))
        else $error("job with K above list length or empty list");
`endif

endmodule

// ===== rtl/tkr_engine.sv =====
// ============================================================================
// tkr_engine - ranking back end
// Per element, counts the elements that win against it with one comparator.
// ============================================================================
module tkr_engine
    import tkr_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_job_valid,
    input  logic [2*$clog2(MAX_ENTRIES+1)-1:0]    i_job,   // {k, n}
    output logic                                  o_job_pop,
    output logic [$clog2(MAX_ENTRIES)-1:0]        o_raddr_a,
    input  logic [VALUE_W-1:0]                    i_rdata_a,
    output logic [$clog2(MAX_ENTRIES)-1:0]        o_raddr_b,
    input  logic [VALUE_W-1:0]                    i_rdata_b,
    output logic                                  o_res_push,
    output t_result                               o_res,
    input  logic                                  i_res_full,
    output t_eng_status                           o_status
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES+1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_eng_state;

    t_eng_state    r_state, n_state;
    logic [CW-1:0] r_n, n_n, r_k, n_k, r_cnt, n_cnt;
    logic [AW-1:0] r_i, n_i, r_j, n_j, r_pend_j, n_pend_j;
    logic          r_pend, n_pend;
    logic          w_wins, w_last_i, w_ranked;
    logic [CW-1:0] w_rank;

    assign o_raddr_a = r_i;
    assign o_raddr_b = r_j;

    // element j goes before element i: larger value, or equal and earlier
    assign w_wins = r_pend &&
        (($signed(i_rdata_b) > $signed(i_rdata_a)) ||
         ((i_rdata_b == i_rdata_a) && (r_pend_j < r_i)));

    assign w_last_i = (CW'(r_i) == (r_n - 1'b1));
    assign w_ranked = (r_cnt < r_k);
    assign w_rank   = r_k - 1'b1 - r_cnt;

    assign o_res.position    = POS_W'(r_i);
    assign o_res.rank        = w_ranked ? RANK_W'(w_rank) : '0;
    assign o_res.ranked      = w_ranked;
    assign o_res.last_result = w_last_i;

    assign o_job_pop     = (r_state == S_IDLE) && i_job_valid;
    assign o_res_push    = (r_state == S_EMIT) && !i_res_full;
    assign o_status.busy = (r_state != S_IDLE);
    assign o_status.done = o_res_push && w_last_i;

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_k      = r_k;
        n_i      = r_i;
        n_j      = r_j;
        n_pend   = 1'b0;
        n_pend_j = r_pend_j;
        n_cnt    = r_cnt + (w_wins ? CW'(1) : CW'(0));
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_n     = i_job[CW-1:0];
                    n_k     = i_job[2*CW-1:CW];
                    n_i     = '0;
                    n_j     = '0;
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_pend   = 1'b1;
                n_pend_j = r_j;
                if (CW'(r_j) == (r_n - 1'b1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_res_full) begin
                    if (w_last_i) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_j     = '0;
                        n_cnt   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
        r_n      <= n_n;
        r_k      <= n_k;
        r_i      <= n_i;
        r_j      <= n_j;
        r_pend_j <= n_pend_j;
        r_cnt    <= n_cnt;
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_cnt < r_n))
        else $error("winner count reaches list length");
    a_scan_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_j) < r_n && CW'(r_i) < r_n))
        else $error("scan address beyond list");
    a_drain_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> r_pend)
        else $error("last compare missing at scan end");
`endif

endmodule
